// ----- sv/mans_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mans_pkg
// Types, request codes and BCD time helpers shared by the next-alarm
// selector modules.
// ----------------------------------------------------------------------------
package mans_pkg;

    localparam int TIME_W = 11;

    typedef logic [TIME_W-1:0] alarm_time_t;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_ADD  = 2'd1;
    localparam logic [1:0] REQ_DEL  = 2'd2;

    localparam logic [4:0] HOUR_SAT   = 5'd31;
    localparam logic [5:0] MINUTE_SAT = 6'd63;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic [1:0] slot_index;
        logic [5:0] now_hour_bcd;
        logic [6:0] now_minute_bcd;
    } in_t;

    typedef struct packed {
        logic       alarm_on;
        logic       next_valid;
        logic [4:0] next_hour;
        logic [5:0] next_minute;
        logic [1:0] alarm_count;
        logic       rejected;
    } out_t;

    // tens digit * 10 + units digit, no digit check, saturated
    function automatic logic [4:0] bcd_hour(input logic [5:0] v);
        logic [5:0] d;
        d = 6'({v[5:4], 3'b000}) + 6'({v[5:4], 1'b0}) + 6'(v[3:0]);
        return (d > 6'(HOUR_SAT)) ? HOUR_SAT : d[4:0];
    endfunction

    function automatic logic [5:0] bcd_minute(input logic [6:0] v);
        logic [6:0] d;
        d = 7'({v[6:4], 3'b000}) + 7'({v[6:4], 1'b0}) + 7'(v[3:0]);
        return (d > 7'(MINUTE_SAT)) ? MINUTE_SAT : d[5:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/mans_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mans_cmp
// Shared compare unit: decides whether the scanned entry replaces the
// current best candidate.
// ----------------------------------------------------------------------------
module mans_cmp (
    input  wire mans_pkg::alarm_time_t entry,
    input  wire mans_pkg::alarm_time_t last_time,
    input  wire mans_pkg::alarm_time_t best_time,
    input  wire                        found,
    input  wire                        wrap_pass,
    output logic                       take
);

    logic ahead;
    logic earlier;

    assign ahead   = wrap_pass || (entry >= last_time);
    assign earlier = !found || (entry < best_time);
    assign take    = ahead && earlier;

endmodule
`default_nettype wire

// ----- sv/mans_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mans_table
// Alarm table storage: append at one slot, remove one slot closing the gap,
// one read port for the scan.
// ----------------------------------------------------------------------------
module mans_table #(
    parameter int SLOTS = 3,
    parameter int IDX_W = 2
) (
    input  wire                        aclk,
    input  wire                        wr_en,
    input  wire [IDX_W-1:0]            wr_idx,
    input  wire mans_pkg::alarm_time_t wr_data,
    input  wire                        rm_en,
    input  wire [IDX_W-1:0]            rm_idx,
    input  wire [IDX_W-1:0]            rd_idx,
    output mans_pkg::alarm_time_t      rd_data
);

    mans_pkg::alarm_time_t entry_reg [SLOTS];

    for (genvar g = 0; g < SLOTS; g++) begin : g_entry
        if (g < SLOTS - 1) begin : g_shift
            always_ff @(posedge aclk) begin
                if (rm_en && (rm_idx <= IDX_W'(g))) begin
                    entry_reg[g] <= entry_reg[g+1];
                end else if (wr_en && (wr_idx == IDX_W'(g))) begin
                    entry_reg[g] <= wr_data;
                end
            end
        end else begin : g_last
            always_ff @(posedge aclk) begin
                if (wr_en && !rm_en && (wr_idx == IDX_W'(g))) begin
                    entry_reg[g] <= wr_data;
                end
            end
        end
    end

    assign rd_data = entry_reg[rd_idx];

endmodule
`default_nettype wire

// ----- sv/multi_alarm_next_selector_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_alarm_next_selector_core
// Daily alarm table with next-alarm selection and one-shot match removal.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one request transaction: a clock tick with
//   the BCD time, an alarm add or a slot delete. m_valid/m_ready/m_data
//   return one status transaction per request.
//   The block handles one request at a time; s_ready is high only while the
//   sequencer is idle. A request that needs no new pick goes from the execute
//   state straight to the result state. A re-pick scans the table one entry
//   per cycle through a single compare unit; when no alarm lies ahead of the
//   current time, the scan wraps and makes a second pass over the table.
//   The next request can be accepted once the result is registered.
//   A stalled m_ready holds the result in the output register; a following
//   request may be accepted and worked on, and its result waits until the
//   output register is free.
//   Reset (aresetn low, synchronous) empties the table, clears the
//   selection, the match flag and the last tick time; no clearing pass.
// ----------------------------------------------------------------------------
module multi_alarm_next_selector_core #(
    parameter int SLOTS = 3
) (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  wire mans_pkg::in_t  s_data,
    output logic           m_valid,
    input  wire            m_ready,
    output mans_pkg::out_t m_data
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    mans_pkg::in_t         req_reg, req_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      next_slot_reg, next_slot_next;
    mans_pkg::alarm_time_t next_time_reg, next_time_next;
    logic                  next_present_reg, next_present_next;
    logic                  fired_reg, fired_next;
    mans_pkg::alarm_time_t last_time_reg, last_time_next;
    logic                  rej_reg, rej_next;
    logic [CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  pass_reg, pass_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    mans_pkg::alarm_time_t best_t_reg, best_t_next;
    logic                  m_valid_reg, m_valid_next;
    mans_pkg::out_t        m_data_reg, m_data_next;

    logic                  tbl_wr_en;
    logic                  tbl_rm_en;
    logic [IDX_W-1:0]      tbl_rm_idx;
    mans_pkg::alarm_time_t tbl_rd_data;
    logic                  take;

    mans_pkg::alarm_time_t tick_time;
    logic [4:0]            del_idx_w;
    logic [4:0]            cnt_w;
    logic [4:0]            slot_w;
    logic [CNT_W+1:0]      cnt_out;

    assign tick_time = {mans_pkg::bcd_hour(req_reg.now_hour_bcd),
                        mans_pkg::bcd_minute(req_reg.now_minute_bcd)};
    assign del_idx_w = 5'(req_reg.slot_index);
    assign cnt_w     = 5'(count_reg);
    assign slot_w    = 5'(next_slot_reg);
    assign cnt_out   = (CNT_W+2)'(count_reg);

    mans_table #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_idx  (count_reg[IDX_W-1:0]),
        .wr_data ({req_reg.alarm_hour, req_reg.alarm_minute}),
        .rm_en   (tbl_rm_en),
        .rm_idx  (tbl_rm_idx),
        .rd_idx  (scan_idx_reg[IDX_W-1:0]),
        .rd_data (tbl_rd_data)
    );

    mans_cmp u_cmp (
        .entry     (tbl_rd_data),
        .last_time (last_time_reg),
        .best_time (best_t_reg),
        .found     (found_reg),
        .wrap_pass (pass_reg),
        .take      (take)
    );

    always_comb begin
        state_next        = state_reg;
        req_next          = req_reg;
        count_next        = count_reg;
        next_slot_next    = next_slot_reg;
        next_time_next    = next_time_reg;
        next_present_next = next_present_reg;
        fired_next        = fired_reg;
        last_time_next    = last_time_reg;
        rej_next          = rej_reg;
        scan_idx_next     = scan_idx_reg;
        pass_next         = pass_reg;
        found_next        = found_reg;
        best_idx_next     = best_idx_reg;
        best_t_next       = best_t_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;
        tbl_wr_en         = 1'b0;
        tbl_rm_en         = 1'b0;
        tbl_rm_idx        = next_slot_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                rej_next      = 1'b0;
                scan_idx_next = '0;
                pass_next     = 1'b0;
                found_next    = 1'b0;
                best_idx_next = '0;
                best_t_next   = '0;
                state_next    = ST_DONE;
                case (req_reg.req_type)
                    mans_pkg::REQ_TICK: begin
                        last_time_next = tick_time;
                        if (next_present_reg && (tick_time == next_time_reg)) begin
                            // first matching tick removes the entry, later ones hold
                            if (!fired_reg && (slot_w < cnt_w)) begin
                                tbl_rm_en  = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                            fired_next = 1'b1;
                        end else begin
                            fired_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                    end
                    mans_pkg::REQ_ADD: begin
                        if (cnt_w >= 5'(SLOTS)) begin
                            rej_next = 1'b1;
                        end else begin
                            tbl_wr_en  = 1'b1;
                            count_next = count_reg + 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                    mans_pkg::REQ_DEL: begin
                        if (del_idx_w < cnt_w) begin
                            tbl_rm_en  = 1'b1;
                            tbl_rm_idx = IDX_W'(req_reg.slot_index);
                            count_next = count_reg - 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                if (scan_idx_reg < count_reg) begin
                    if (take) begin
                        found_next    = 1'b1;
                        best_idx_next = scan_idx_reg[IDX_W-1:0];
                        best_t_next   = tbl_rd_data;
                    end
                    scan_idx_next = scan_idx_reg + 1'b1;
                end else if (!pass_reg && !found_reg) begin
                    // nothing ahead of now: wrap to the earliest overall
                    pass_next     = 1'b1;
                    scan_idx_next = '0;
                end else begin
                    next_present_next = found_reg;
                    next_slot_next    = best_idx_reg;
                    next_time_next    = best_t_reg;
                    state_next        = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.alarm_on     = fired_reg;
                    m_data_next.next_valid   = next_present_reg;
                    m_data_next.next_hour    = next_present_reg ? next_time_reg[10:6] : 5'd0;
                    m_data_next.next_minute  = next_present_reg ? next_time_reg[5:0] : 6'd0;
                    m_data_next.alarm_count  = cnt_out[1:0];
                    m_data_next.rejected     = rej_reg;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            next_slot_reg    <= '0;
            next_time_reg    <= '0;
            next_present_reg <= 1'b0;
            fired_reg        <= 1'b0;
            last_time_reg    <= '0;
            rej_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            next_slot_reg    <= next_slot_next;
            next_time_reg    <= next_time_next;
            next_present_reg <= next_present_next;
            fired_reg        <= fired_next;
            last_time_reg    <= last_time_next;
            rej_reg          <= rej_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        scan_idx_reg <= scan_idx_next;
        pass_reg     <= pass_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_t_reg   <= best_t_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_w <= 5'(SLOTS))
        else $error("alarm count above table size");

    a_blank_when_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.next_valid) |-> (m_data.next_hour == 5'd0 &&
                                             m_data.next_minute == 6'd0))
        else $error("next time not blank without a selection");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.rejected) |-> (m_data.alarm_count == 2'(SLOTS)))
        else $error("add rejected while table not full");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in progress");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_multi_alarm_next_selector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_alarm_next_selector_core
// Self-checking bench for the next-alarm selector. A queue of requests
// (directed corner cases, then random add/delete/tick sequences that aim
// ticks at stored alarms) feeds a valid/ready driver. Every accepted request
// is run through a local model of the alarm table, and the expected status
// is compared field by field with each status transaction from the block.
// Both sides idle at random, and the status side stalls once for a long
// stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_multi_alarm_next_selector_core;

    localparam int SLOTS        = 3;
    localparam int IN_W         = $bits(mans_pkg::in_t);
    localparam int N_RANDOM     = 1730;
    localparam int MAX_WAIT     = 6;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    mans_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    mans_pkg::out_t m_data;

    multi_alarm_next_selector_core #(
        .SLOTS(SLOTS)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Local copy of the alarm table and selection state
    // ------------------------------------------------------------------
    mans_pkg::alarm_time_t tbl [SLOTS] = '{default: '0};
    int unsigned           n_stored    = 0;
    int unsigned           sel_idx     = 0;
    mans_pkg::alarm_time_t sel_at      = '0;
    bit                    sel_ok      = 1'b0;
    bit                    ringing     = 1'b0;
    mans_pkg::alarm_time_t last_tick   = '0;

    mans_pkg::in_t  pending [$];
    mans_pkg::out_t status_due [$];

    int unsigned cycle_cnt  = 0;
    int unsigned gap_cnt    = 0;
    int unsigned stall_cnt  = 0;
    int unsigned hold_cnt   = 0;
    int unsigned n_errors   = 0;
    int unsigned n_results  = 0;
    int unsigned n_ticks    = 0;
    int unsigned n_adds     = 0;
    int unsigned n_dels     = 0;
    int unsigned n_other    = 0;
    int unsigned n_ringing  = 0;
    int unsigned n_refused  = 0;

    function automatic logic [5:0] decode_bcd(input logic [6:0] v, input int unsigned cap);
        int unsigned d;
        d = int'(v[6:4]) * 10 + int'(v[3:0]);
        return (d > cap) ? 6'(cap) : 6'(d);
    endfunction

    // earliest entry at or after the last tick, else earliest overall; lowest index wins ties
    function automatic void reselect();
        bit                    found;
        int unsigned           best;
        mans_pkg::alarm_time_t best_at;
        int unsigned           i;
        found   = 1'b0;
        best    = 0;
        best_at = '0;
        for (i = 0; i < n_stored; i++) begin
            if (tbl[i] >= last_tick && (!found || tbl[i] < best_at)) begin
                found   = 1'b1;
                best    = i;
                best_at = tbl[i];
            end
        end
        if (!found) begin
            for (i = 0; i < n_stored; i++) begin
                if (!found || tbl[i] < best_at) begin
                    found   = 1'b1;
                    best    = i;
                    best_at = tbl[i];
                end
            end
        end
        sel_ok  = found;
        sel_idx = best;
        sel_at  = best_at;
    endfunction

    function automatic void drop_entry(input int unsigned idx);
        int unsigned i;
        if (idx < n_stored) begin
            for (i = idx; i + 1 < n_stored; i++)
                tbl[i] = tbl[i + 1];
            n_stored--;
        end
    endfunction

    function automatic mans_pkg::out_t apply_request(input mans_pkg::in_t rq);
        mans_pkg::out_t st;
        bit             refused;
        logic [5:0]     hr;
        logic [5:0]     mn;
        refused = 1'b0;
        case (rq.req_type)
            mans_pkg::REQ_TICK: begin
                hr = decode_bcd({1'b0, rq.now_hour_bcd}, int'(mans_pkg::HOUR_SAT));
                mn = decode_bcd(rq.now_minute_bcd, int'(mans_pkg::MINUTE_SAT));
                last_tick = {hr[4:0], mn};
                if (sel_ok && last_tick == sel_at) begin
                    // only the first matching tick removes the entry
                    if (!ringing) begin
                        drop_entry(sel_idx);
                        ringing = 1'b1;
                    end
                end else begin
                    ringing = 1'b0;
                    reselect();
                end
            end
            mans_pkg::REQ_ADD: begin
                if (n_stored >= SLOTS) begin
                    refused = 1'b1;
                end else begin
                    tbl[n_stored] = {rq.alarm_hour, rq.alarm_minute};
                    n_stored++;
                    reselect();
                end
            end
            mans_pkg::REQ_DEL: begin
                if (int'(rq.slot_index) < n_stored) begin
                    drop_entry(int'(rq.slot_index));
                    reselect();
                end
            end
            default: ;
        endcase
        st.alarm_on    = ringing;
        st.next_valid  = sel_ok;
        st.next_hour   = sel_ok ? sel_at[10:6] : 5'd0;
        st.next_minute = sel_ok ? sel_at[5:0] : 6'd0;
        st.alarm_count = 2'(n_stored);
        st.rejected    = refused;
        return st;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // no idling at all in one stretch out of four
    function automatic int unsigned draw_wait();
        if ((cycle_cnt / 1500) % 4 == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // ------------------------------------------------------------------
    // Request queue builders
    // ------------------------------------------------------------------
    function automatic mans_pkg::in_t random_item();
        return mans_pkg::in_t'(IN_W'($urandom));
    endfunction

    function automatic logic [6:0] to_bcd(input int unsigned v);
        return {3'(v / 10), 4'(v % 10)};
    endfunction

    function automatic void queue_tick(input logic [5:0] hour_bcd, input logic [6:0] min_bcd);
        mans_pkg::in_t it;
        it                = random_item();
        it.req_type       = mans_pkg::REQ_TICK;
        it.now_hour_bcd   = hour_bcd;
        it.now_minute_bcd = min_bcd;
        pending.push_back(it);
    endfunction

    function automatic void queue_tick_at(input mans_pkg::alarm_time_t t);
        logic [6:0] hb;
        hb = to_bcd(int'(t[10:6]));
        queue_tick(hb[5:0], to_bcd(int'(t[5:0])));
    endfunction

    function automatic void queue_add(input mans_pkg::alarm_time_t t);
        mans_pkg::in_t it;
        it              = random_item();
        it.req_type     = mans_pkg::REQ_ADD;
        it.alarm_hour   = t[10:6];
        it.alarm_minute = t[5:0];
        pending.push_back(it);
    endfunction

    function automatic void queue_del(input logic [1:0] idx);
        mans_pkg::in_t it;
        it            = random_item();
        it.req_type   = mans_pkg::REQ_DEL;
        it.slot_index = idx;
        pending.push_back(it);
    endfunction

    initial begin : stimulus
        mans_pkg::alarm_time_t recent [$];
        mans_pkg::alarm_time_t clk_at;
        mans_pkg::alarm_time_t target;
        mans_pkg::in_t         raw;
        int unsigned           made;
        int unsigned           pick;
        int unsigned           mins;
        int unsigned           k;
        int unsigned           i;
        bit                    found;

        // directed corner cases
        queue_tick(6'h00, 7'h00);           // empty table
        queue_del(2'd0);                    // delete of an empty slot
        raw = random_item();
        raw.req_type = REQ_UNKNOWN;
        pending.push_back(raw);
        queue_add({5'd23, 6'd59});
        queue_add({5'd7, 6'd30});
        queue_add({5'd7, 6'd30});           // tie, lower index stays selected
        queue_add({5'd12, 6'd0});           // table full
        queue_tick(6'h07, 7'h30);           // match removes the entry
        queue_tick(6'h07, 7'h30);           // repeated match keeps everything
        queue_tick(6'h07, 7'h31);           // no match: output off, new pick
        queue_tick(6'h3F, 7'h7F);           // both digits saturate, pick wraps
        queue_add({5'd31, 6'd63});          // out-of-range alarm stored as is
        queue_tick(6'h31, 7'h63);
        queue_del(2'd3);
        queue_del(2'd2);
        queue_del(2'd0);
        queue_add({5'd0, 6'd0});
        queue_tick(6'h00, 7'h00);
        queue_tick(6'h12, 7'h00);
        queue_add({5'd12, 6'd0});           // pick equal to the current time stays quiet
        queue_tick(6'h12, 7'h00);
        queue_del(2'd1);
        queue_del(2'd0);
        queue_del(2'd0);
        queue_tick(6'h24, 7'h00);

        made   = 0;
        clk_at = '0;
        while (made < N_RANDOM) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                raw = random_item();
                pending.push_back(raw);
                if (raw.req_type != REQ_UNKNOWN)
                    made++;
            end else if (pick < 32) begin
                if ($urandom_range(0, 9) == 0)
                    target = mans_pkg::alarm_time_t'($urandom);
                else
                    target = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59))};
                queue_add(target);
                recent.push_back(target);
                if (recent.size() > SLOTS)
                    void'(recent.pop_front());
                made++;
            end else if (pick < 44) begin
                queue_del(2'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 3 : 2)));
                made++;
            end else if (recent.size() != 0 && $urandom_range(0, 99) < 40) begin
                // aim at the alarm the block should have selected
                found = 1'b0;
                k     = 0;
                for (i = 0; i < recent.size(); i++) begin
                    if (recent[i] >= clk_at && (!found || recent[i] < recent[k])) begin
                        found = 1'b1;
                        k     = i;
                    end
                end
                if (!found) begin
                    for (i = 0; i < recent.size(); i++)
                        if (recent[i] < recent[k])
                            k = i;
                end
                clk_at = recent[k];
                recent.delete(k);
                queue_tick_at(clk_at);
                made++;
                if ($urandom_range(0, 1) == 1) begin
                    queue_tick_at(clk_at);
                    made++;
                end
            end else begin
                mins   = (int'(clk_at[10:6]) * 60 + int'(clk_at[5:0])
                          + $urandom_range(1, 180)) % 1440;
                clk_at = {5'(mins / 60), 6'(mins % 60)};
                queue_tick_at(clk_at);
                made++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        int unsigned wait_n;
        wait_n = gap_cnt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cnt <= 0;
        end else begin
            if (s_valid && s_ready) begin
                status_due.push_back(apply_request(s_data));
                case (s_data.req_type)
                    mans_pkg::REQ_TICK: n_ticks++;
                    mans_pkg::REQ_ADD:  n_adds++;
                    mans_pkg::REQ_DEL:  n_dels++;
                    default:            n_other++;
                endcase
            end
            if (!s_valid || s_ready) begin
                if (wait_n != 0) begin
                    s_valid <= 1'b0;
                    wait_n--;
                end else if (pending.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending.pop_front();
                    wait_n = draw_wait();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            gap_cnt <= wait_n;
        end
    end

    // ------------------------------------------------------------------
    // Status monitor and checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        int unsigned    stall_n;
        int unsigned    hold_n;
        mans_pkg::out_t due;
        stall_n = stall_cnt;
        hold_n  = hold_cnt;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
            hold_cnt  <= 0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (status_due.size() == 0) begin
                    n_errors++;
                    $display("%0t: status transaction with none expected, actual %h",
                             $time, m_data);
                end else begin
                    due = status_due.pop_front();
                    check_field("alarm_on", due.alarm_on, m_data.alarm_on);
                    check_field("next_valid", due.next_valid, m_data.next_valid);
                    check_field("next_hour", due.next_hour, m_data.next_hour);
                    check_field("next_minute", due.next_minute, m_data.next_minute);
                    check_field("alarm_count", due.alarm_count, m_data.alarm_count);
                    check_field("rejected", due.rejected, m_data.rejected);
                end
                if (m_data.alarm_on)
                    n_ringing++;
                if (m_data.rejected)
                    n_refused++;
                stall_n = draw_wait();
                // one long back-pressure stretch to fill the block up
                if (n_results == HOLD_AT)
                    hold_n = HOLD_LEN;
            end
            if (hold_n != 0) begin
                m_ready <= 1'b0;
                hold_n--;
            end else if (stall_n != 0) begin
                m_ready <= 1'b0;
                stall_n--;
            end else begin
                m_ready <= 1'b1;
            end
            stall_cnt <= stall_n;
            hold_cnt  <= hold_n;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles, %0d statuses outstanding",
                     cycle_cnt, status_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : run_end
        wait (aresetn === 1'b1);
        @(negedge aclk);
        while (pending.size() != 0 || s_valid || status_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Requests: %0d ticks, %0d adds, %0d deletes, %0d unknown codes.",
                 n_ticks, n_adds, n_dels, n_other);
        $display("Statuses checked: %0d, alarm on in %0d, full-table refusals %0d, errors %0d.",
                 n_results, n_ringing, n_refused, n_errors);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- multi_alarm_next_selector_core.f -----
sv/mans_pkg.sv
sv/mans_cmp.sv
sv/mans_table.sv
sv/multi_alarm_next_selector_core.sv
dv/tb_multi_alarm_next_selector_core.sv
